// File: rtl/core/laq_pkg.sv
// package: payload types, cordic constants and helpers for look_at_quaternion
package laq_pkg;

    localparam int MaxStages = 24;

    localparam logic signed [35:0] AngPiHalf = 36'sd26353589;
    localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;
    localparam logic signed [16:0] OneQ14 = 17'sd16384;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic signed [15:0] joint_x;
        logic signed [15:0] joint_y;
        logic signed [15:0] joint_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } out_item_t;

    function automatic logic signed [35:0] atan_entry(input int i);
        logic signed [35:0] r;
        case (i)
            0: r = 36'sd13176795;
            1: r = 36'sd7778716;
            2: r = 36'sd4110060;
            3: r = 36'sd2086331;
            4: r = 36'sd1047214;
            5: r = 36'sd524117;
            6: r = 36'sd262123;
            7: r = 36'sd131069;
            default: r = 36'sd1 <<< (24 - i);
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/laq_vec.sv
// vectoring cordic pipeline: angle of (y, x) in q.24
module laq_vec #(
    parameter int STAGES = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [16:0]  y_in,
    input  logic signed [16:0]  x_in,
    output logic signed [35:0]  ang_out
);
    // x,y grow to at most about 2^29.2 after the quarter turn and gain
    logic signed [32:0] x_reg [STAGES+1];
    logic signed [32:0] y_reg [STAGES+1];
    logic signed [35:0] a_reg [STAGES+1];
    logic               z_reg [STAGES+1];

    logic signed [32:0] xs, ys;
    logic signed [32:0] x0, y0;
    logic signed [35:0] a0;

    always_comb begin
        xs = 33'(x_in) <<< 12;
        ys = 33'(y_in) <<< 12;
        x0 = xs;
        y0 = ys;
        a0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                x0 = ys;
                y0 = -xs;
                a0 = laq_pkg::AngPiHalf;
            end else begin
                x0 = -ys;
                y0 = xs;
                a0 = -laq_pkg::AngPiHalf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            a_reg[0] <= a0;
            z_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                z_reg[i+1] <= z_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + laq_pkg::atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - laq_pkg::atan_entry(i);
                end
            end
        end
    end

    assign ang_out = z_reg[STAGES] ? '0 : a_reg[STAGES];
endmodule

// File: rtl/core/laq_rot.sv
// rotation cordic pipeline: cos and sin of a q.24 angle in q.30
module laq_rot #(
    parameter int STAGES = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [35:0]  ang_in,
    output logic signed [31:0]  cos_out,
    output logic signed [31:0]  sin_out
);
    logic signed [32:0] x_reg [STAGES+1];
    logic signed [32:0] y_reg [STAGES+1];
    logic signed [35:0] a_reg [STAGES+1];
    logic signed [1:0]  q_reg [STAGES+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= 33'(laq_pkg::InvGainQ30);
            y_reg[0] <= '0;
            if (ang_in > laq_pkg::AngPiHalf) begin
                a_reg[0] <= ang_in - laq_pkg::AngPiHalf;
                q_reg[0] <= 2'sd1;
            end else if (ang_in < -laq_pkg::AngPiHalf) begin
                a_reg[0] <= ang_in + laq_pkg::AngPiHalf;
                q_reg[0] <= -2'sd1;
            end else begin
                a_reg[0] <= ang_in;
                q_reg[0] <= 2'sd0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i+1] <= q_reg[i];
                if (a_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - laq_pkg::atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + laq_pkg::atan_entry(i);
                end
            end
        end
    end

    logic signed [32:0] c_full, s_full;
    always_comb begin
        if (q_reg[STAGES] == 2'sd1) begin
            c_full = -y_reg[STAGES];
            s_full = x_reg[STAGES];
        end else if (q_reg[STAGES] == -2'sd1) begin
            c_full = y_reg[STAGES];
            s_full = -x_reg[STAGES];
        end else begin
            c_full = x_reg[STAGES];
            s_full = y_reg[STAGES];
        end
    end
    assign cos_out = c_full[31:0];
    assign sin_out = s_full[31:0];
endmodule

// File: rtl/core/look_at_quaternion.sv
// look_at_quaternion: top level, difference, angle and quaternion pipeline
// Accepts one item per cycle while ready is high and delivers results in
// order through the two chained unrolled cordic pipelines (vectoring for
// the angles, rotation for the half-angle sin/cos) plus the difference,
// half-angle, product, rounding and sign stages. Ready drops only when the
// output register holds a result that is not taken, and then the whole
// pipeline holds.
module look_at_quaternion #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  laq_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output laq_pkg::out_item_t  m_data
);
    localparam int Lat = 2 * CORDIC_STAGES + 6;

    logic en;
    logic vld_reg [Lat+1];
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // difference stage
    logic signed [16:0] dx_reg, dy_reg, dz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= 17'(s_data.target_x) - 17'(s_data.joint_x);
            dy_reg <= 17'(s_data.target_y) - 17'(s_data.joint_y);
            dz_reg <= 17'(s_data.target_z) - 17'(s_data.joint_z);
        end
    end

    logic signed [35:0] ap, ay;
    laq_vec #(.STAGES(CORDIC_STAGES)) u_vp (
        .aclk(aclk), .en(en), .y_in(dy_reg), .x_in(dz_reg), .ang_out(ap));
    laq_vec #(.STAGES(CORDIC_STAGES)) u_vy (
        .aclk(aclk), .en(en), .y_in(dz_reg), .x_in(dx_reg), .ang_out(ay));

    logic signed [35:0] hp_reg, hy_reg;
    logic signed [35:0] pitch, yaw;
    assign pitch = -ap;
    assign yaw = laq_pkg::AngPiHalf - ay;
    always_ff @(posedge aclk) begin
        if (en) begin
            hp_reg <= pitch >>> 1;
            hy_reg <= yaw >>> 1;
        end
    end

    logic signed [31:0] cx, sx, cy, sy;
    laq_rot #(.STAGES(CORDIC_STAGES)) u_rp (
        .aclk(aclk), .en(en), .ang_in(hp_reg), .cos_out(cx), .sin_out(sx));
    laq_rot #(.STAGES(CORDIC_STAGES)) u_ry (
        .aclk(aclk), .en(en), .ang_in(hy_reg), .cos_out(cy), .sin_out(sy));

    logic signed [63:0] p_reg [4];
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= cy * cx;
            p_reg[1] <= cy * sx;
            p_reg[2] <= sy * cx;
            p_reg[3] <= sy * sx;
        end
    end

    logic signed [16:0] r_reg [4];
    logic signed [63:0] rnd [4];
    logic signed [17:0] sat [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (p_reg[k] + (64'sd1 <<< 45)) >>> 46;
            if (rnd[k] > 64'(laq_pkg::OneQ14)) sat[k] = 18'(laq_pkg::OneQ14);
            else if (rnd[k] < -64'(laq_pkg::OneQ14)) sat[k] = -18'(laq_pkg::OneQ14);
            else sat[k] = rnd[k][17:0];
        end
        sat[3] = -sat[3];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) r_reg[k] <= sat[k][16:0];
        end
    end

    logic [16:0] mag [4];
    logic        neg;
    logic [16:0] m;
    logic        mneg;
    always_comb begin
        for (int k = 0; k < 4; k++) mag[k] = r_reg[k] < 0 ? 17'(-r_reg[k]) : 17'(r_reg[k]);
        m = mag[0];
        mneg = r_reg[0] < 0;
        for (int k = 1; k < 4; k++) begin
            if (mag[k] > m) begin
                m = mag[k];
                mneg = r_reg[k] < 0;
            end
        end
        neg = mneg;
    end

    laq_pkg::out_item_t out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.quat_w <= neg ? 16'(-r_reg[0]) : r_reg[0][15:0];
            out_reg.quat_x <= neg ? 16'(-r_reg[1]) : r_reg[1][15:0];
            out_reg.quat_y <= neg ? 16'(-r_reg[2]) : r_reg[2][15:0];
            out_reg.quat_z <= neg ? 16'(-r_reg[3]) : r_reg[3][15:0];
        end
    end
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= Lat; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k <= Lat; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end
    assign m_valid = vld_reg[Lat];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline stalled without a waiting result");
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.quat_w >= -16'sd16384 && m_data.quat_w <= 16'sd16384)
        else $error("component out of range");
endmodule

// File: tb/tb_look_at_quaternion.sv
// testbench: random and directed look-at vectors checked against a fixed-point quaternion predictor
module tb_look_at_quaternion;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Stages = 16;
    localparam int Latency = 2 * Stages + 7;
    localparam int WatchLimit = 20 * Latency + 200;
    localparam longint PiHalfQ24 = 64'sd26353589;
    localparam longint InvGain = 64'sd652032874;
    localparam longint OneQ14L = 64'sd16384;

    function automatic longint atan_q24(int i);
        case (i)
            0: return 13176795;
            1: return 7778716;
            2: return 4110060;
            3: return 2086331;
            4: return 1047214;
            5: return 524117;
            6: return 262123;
            7: return 131069;
            default: return 64'sd1 <<< (24 - i);
        endcase
    endfunction

    function automatic longint heading_angle(longint y, longint x);
        longint a, t, nx;
        a = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 4096;
        y = y * 4096;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; a = PiHalfQ24;
            end else begin
                x = -y; y = t; a = -PiHalfQ24;
            end
        end
        for (int i = 0; i < Stages; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); a += atan_q24(i);
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); a -= atan_q24(i);
            end
            x = nx;
        end
        return a;
    endfunction

    function automatic void half_sincos(longint a, output longint c, output longint s);
        longint x, y, nx;
        int quad;
        x = InvGain; y = 0; quad = 0;
        if (a > PiHalfQ24) begin
            a -= PiHalfQ24; quad = 1;
        end else if (a < -PiHalfQ24) begin
            a += PiHalfQ24; quad = -1;
        end
        for (int i = 0; i < Stages; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); a -= atan_q24(i);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); a += atan_q24(i);
            end
            x = nx;
        end
        if (quad == 1) begin
            c = -y; s = x;
        end else if (quad == -1) begin
            c = y; s = -x;
        end else begin
            c = x; s = y;
        end
    endfunction

    function automatic longint prod_q14(longint a, longint b);
        longint r;
        r = (a * b + (64'sd1 <<< 45)) >>> 46;
        if (r > OneQ14L) r = OneQ14L;
        if (r < -OneQ14L) r = -OneQ14L;
        return r;
    endfunction

    function automatic laq_pkg::out_item_t orientation_of(laq_pkg::in_item_t p);
        longint dx, dy, dz, pitch, yaw, cx, sx, cy, sy, m, v;
        longint q[4];
        int best;
        laq_pkg::out_item_t r;
        dx = longint'(p.target_x) - longint'(p.joint_x);
        dy = longint'(p.target_y) - longint'(p.joint_y);
        dz = longint'(p.target_z) - longint'(p.joint_z);
        pitch = -heading_angle(dy, dz);
        yaw = PiHalfQ24 - heading_angle(dz, dx);
        half_sincos(pitch >>> 1, cx, sx);
        half_sincos(yaw >>> 1, cy, sy);
        q[0] = prod_q14(cy, cx);
        q[1] = prod_q14(cy, sx);
        q[2] = prod_q14(sy, cx);
        q[3] = -prod_q14(sy, sx);
        best = 0;
        m = q[0] < 0 ? -q[0] : q[0];
        for (int k = 1; k < 4; k++) begin
            v = q[k] < 0 ? -q[k] : q[k];
            if (v > m) begin
                m = v; best = k;
            end
        end
        if (q[best] < 0)
            for (int k = 0; k < 4; k++) q[k] = -q[k];
        r.quat_w = q[0][15:0];
        r.quat_x = q[1][15:0];
        r.quat_y = q[2][15:0];
        r.quat_z = q[3][15:0];
        return r;
    endfunction

    class quat_scoreboard;
        laq_pkg::out_item_t pending_quats[$];
        int mismatches;

        function void note_point(laq_pkg::in_item_t p);
            pending_quats.push_back(orientation_of(p));
        endfunction

        function void check_quat(laq_pkg::out_item_t got);
            laq_pkg::out_item_t exp_q;
            if (pending_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", got);
                return;
            end
            exp_q = pending_quats.pop_front();
            if (got.quat_w !== exp_q.quat_w || got.quat_x !== exp_q.quat_x ||
                got.quat_y !== exp_q.quat_y || got.quat_z !== exp_q.quat_z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp w%0d x%0d y%0d z%0d got w%0d x%0d y%0d z%0d",
                             exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                             got.quat_w, got.quat_x, got.quat_y, got.quat_z);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    laq_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    laq_pkg::out_item_t m_data;

    quat_scoreboard sb = new();
    bit calm = 0;
    int idle_cycles = 0;

    look_at_quaternion #(.CORDIC_STAGES(Stages)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_point(s_data);
            if (m_valid && m_ready) sb.check_quat(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchLimit) begin
                $display("FAIL look_at_quaternion");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int gap;
        @(negedge aclk);
        forever begin
            m_ready <= 1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 3);
                m_ready <= 0;
                repeat (gap) @(negedge aclk);
            end
        end
    end

    task automatic send_point(laq_pkg::in_item_t p);
        s_data <= p;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic laq_pkg::in_item_t make_point(int tx, int ty, int tz,
                                                     int jx, int jy, int jz);
        laq_pkg::in_item_t p;
        p.target_x = 16'(tx); p.target_y = 16'(ty); p.target_z = 16'(tz);
        p.joint_x = 16'(jx); p.joint_y = 16'(jy); p.joint_z = 16'(jz);
        return p;
    endfunction

    initial begin
        laq_pkg::in_item_t p;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // zero vector, axis directions, negative x/z, extremes
        send_point(make_point(0, 0, 0, 0, 0, 0));
        send_point(make_point(100, 0, 0, 0, 0, 0));
        send_point(make_point(-100, 0, 0, 0, 0, 0));
        send_point(make_point(0, 100, 0, 0, 0, 0));
        send_point(make_point(0, -100, 0, 0, 0, 0));
        send_point(make_point(0, 0, 100, 0, 0, 0));
        send_point(make_point(0, 0, -100, 0, 0, 0));
        send_point(make_point(-5, 7, -9, 0, 0, 0));
        send_point(make_point(-5, -7, -9, 0, 0, 0));
        send_point(make_point(32767, 32767, 32767, -32768, -32768, -32768));
        send_point(make_point(-32768, -32768, -32768, 32767, 32767, 32767));
        send_point(make_point(32767, -32768, 32767, -32768, 32767, -32768));
        send_point(make_point(-32768, 32767, -32768, 32767, -32768, 32767));
        send_point(make_point(1, 1, 1, 0, 0, 0));
        send_point(make_point(-1, -1, -1, 0, 0, 0));
        send_point(make_point(-1, 0, 0, 0, 0, 0));
        send_point(make_point(0, 1, -1, 0, 0, 0));
        send_point(make_point(1234, -4321, 0, 1234, 0, 0));
        for (int n = 0; n < 2000; n++) begin
            if (n == 1000) begin
                s_valid <= 0;
                wait (sb.pending_quats.size() == 0);
                @(negedge aclk);
            end
            if (n == 1700) calm = 1;
            p.target_x = rand_coord(); p.target_y = rand_coord(); p.target_z = rand_coord();
            p.joint_x = rand_coord(); p.joint_y = rand_coord(); p.joint_z = rand_coord();
            send_point(p);
        end
        s_valid <= 0;
        wait (sb.pending_quats.size() == 0);
        repeat (Latency + 10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_quats.size() == 0)
            $display("PASS look_at_quaternion");
        else
            $display("FAIL look_at_quaternion");
        $finish;
    end
endmodule
